FILE: hdl/bsd_pkg.sv
`default_nettype none

package bsd_pkg;

  // Default depth of the frame store, in bytes.
  localparam int unsigned FrameDepthDef = 64;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned PlenW  = 6;
  localparam int unsigned CntW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Escaped bytes must have this bit clear and get it flipped.
  localparam int unsigned StuffBitPos = 5;
  localparam logic [ByteW-1:0] StuffMask = 8'h20;

  // Start byte, type byte and stop byte at the least.
  localparam int unsigned MinFrame = 3;

  localparam logic [ByteW-1:0] StartByteRst  = 8'h7E;
  localparam logic [ByteW-1:0] StopByteRst   = 8'h7C;
  localparam logic [ByteW-1:0] EscapeByteRst = 8'h7D;

  typedef enum logic [KindW-1:0] {
    KIND_MSG      = 2'd0,
    KIND_STUFF    = 2'd1,
    KIND_FRAMING  = 2'd2,
    KIND_OVERSIZE = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START  = 2'd0,
    CFG_STOP   = 2'd1,
    CFG_ESCAPE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] stop_byte;
    logic [ByteW-1:0] escape_byte;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data_byte;
    logic             is_last;
    logic [PlenW-1:0] payload_len;
    logic [CntW-1:0]  stuff_cnt;
    logic [CntW-1:0]  framing_cnt;
    logic [CntW-1:0]  oversize_cnt;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/bsd_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/bsd_ctrl.sv
`default_nettype none

// Per-byte destuffing and framing control, error counters and frame readout.
module bsd_ctrl #(
  parameter int unsigned Depth = bsd_pkg::FrameDepthDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bsd_pkg::cfg_t             cfg_i,
  input  wire logic                      byte_valid_i,
  input  wire logic [bsd_pkg::ByteW-1:0] byte_i,
  output      logic                      byte_ready_o,
  output      logic                      res_valid_o,
  input  wire logic                      res_ready_i,
  output      bsd_pkg::res_t             res_o,
  output      logic                      mem_we_o,
  output      logic [$clog2(Depth)-1:0]  mem_waddr_o,
  output      logic [bsd_pkg::ByteW-1:0] mem_wdata_o,
  output      logic [$clog2(Depth)-1:0]  mem_raddr_o,
  input  wire logic [bsd_pkg::ByteW-1:0] mem_rdata_i
);
  import bsd_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned FW = $clog2(Depth + 1);

  state_e            state_q, state_d;
  logic              esc_q, esc_d;
  logic              inmsg_q, inmsg_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [FW-1:0]     fill_inc;
  logic [CntW-1:0]   stuff_q, stuff_d;
  logic [CntW-1:0]   framing_q, framing_d;
  logic [CntW-1:0]   over_q, over_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [AW-1:0]     last_q, last_d;
  logic [PlenW-1:0]  plen_q, plen_d;
  logic              acc;
  logic              chk_ovf;

  assign byte_ready_o = (state_q == ST_IDLE) && res_ready_i;
  assign acc          = byte_valid_i && byte_ready_o;
  assign fill_inc     = fill_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      esc_q     <= 1'b0;
      inmsg_q   <= 1'b0;
      fill_q    <= '0;
      stuff_q   <= '0;
      framing_q <= '0;
      over_q    <= '0;
      cur_q     <= '0;
      last_q    <= '0;
      plen_q    <= '0;
    end else begin
      state_q   <= state_d;
      esc_q     <= esc_d;
      inmsg_q   <= inmsg_d;
      fill_q    <= fill_d;
      stuff_q   <= stuff_d;
      framing_q <= framing_d;
      over_q    <= over_d;
      cur_q     <= cur_d;
      last_q    <= last_d;
      plen_q    <= plen_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    esc_d       = esc_q;
    inmsg_d     = inmsg_q;
    fill_d      = fill_q;
    stuff_d     = stuff_q;
    framing_d   = framing_q;
    over_d      = over_q;
    cur_d       = cur_q;
    last_d      = last_q;
    plen_d      = plen_q;
    chk_ovf     = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q[AW-1:0];
    mem_wdata_o = byte_i;
    mem_raddr_o = '0;
    res_valid_o = 1'b0;
    res_o.kind        = KIND_MSG;
    res_o.data_byte   = '0;
    res_o.is_last     = 1'b1;
    res_o.payload_len = '0;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (byte_i == cfg_i.escape_byte) begin
            esc_d = 1'b1;
          end else if (esc_q) begin
            esc_d = 1'b0;
            if (byte_i[StuffBitPos]) begin
              inmsg_d     = 1'b0;
              fill_d      = '0;
              stuff_d     = stuff_q + 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_STUFF;
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = byte_i ^ StuffMask;
              fill_d      = fill_inc;
              chk_ovf     = 1'b1;
            end
          end else begin
            mem_we_o = 1'b1;
            fill_d   = fill_inc;
            if (byte_i == cfg_i.stop_byte && inmsg_q) begin
              inmsg_d = 1'b0;
              fill_d  = '0;
              if (fill_inc >= FW'(MinFrame)) begin
                state_d = ST_CHECK;
                plen_d  = PlenW'(fill_inc - FW'(MinFrame));
                last_d  = AW'(fill_q - 1'b1);
              end
            end else begin
              if (byte_i == cfg_i.stop_byte) begin
                fill_d      = '0;
                framing_d   = framing_q + 1'b1;
                res_valid_o = 1'b1;
                res_o.kind  = KIND_FRAMING;
              end
              if (byte_i == cfg_i.start_byte) begin
                if (inmsg_q) begin
                  inmsg_d     = 1'b0;
                  fill_d      = '0;
                  framing_d   = framing_q + 1'b1;
                  res_valid_o = 1'b1;
                  res_o.kind  = KIND_FRAMING;
                end else begin
                  inmsg_d = 1'b1;
                end
              end
              chk_ovf = 1'b1;
            end
          end
          // A misplaced start or stop empties the store, so at most one
          // error result can come out of one byte.
          if (chk_ovf && fill_d == FW'(Depth)) begin
            fill_d      = '0;
            inmsg_d     = 1'b0;
            over_d      = over_q + 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_OVERSIZE;
          end
        end
      end
      ST_CHECK: begin
        // Read data holds the first stored byte of the closed frame.
        mem_raddr_o = AW'(1);
        if (mem_rdata_i == cfg_i.start_byte) begin
          state_d = ST_READ;
          cur_d   = AW'(1);
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        res_valid_o       = 1'b1;
        res_o.data_byte   = mem_rdata_i;
        res_o.is_last     = (cur_q == last_q);
        res_o.payload_len = plen_q;
        mem_raddr_o       = cur_q;
        if (res_ready_i) begin
          if (cur_q == last_q) begin
            state_d = ST_IDLE;
          end else begin
            cur_d       = cur_q + 1'b1;
            mem_raddr_o = cur_d;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_o.stuff_cnt    = stuff_d;
    res_o.framing_cnt  = framing_d;
    res_o.oversize_cnt = over_d;
  end

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (acc || state_q == ST_READ))
    else $error("result raised outside a byte accept or a readout");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> state_q == ST_IDLE)
    else $error("frame store written during readout");

  a_fill_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> fill_q < FW'(Depth))
    else $error("fill count left at store depth");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> (cur_q <= last_q && cur_q != '0))
    else $error("readout index outside the payload");

  a_escape_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && byte_i == cfg_i.escape_byte) |=> esc_q && !inmsg_q == !$past(inmsg_q))
    else $error("escape byte changed frame state");

endmodule

`default_nettype wire

FILE: hdl/byte_stuffing_deframer.sv
`default_nettype none

// Receive-side deframer for a byte-stuffed serial link. Each slave beat carries
// one line byte. An escape byte makes the next byte data with bit 5 flipped (it
// must arrive with bit 5 clear, else a stuffing error is reported and the frame
// is dropped). Plain bytes, inside or outside a frame, go into a frame store of
// FRAME_DEPTH bytes held in a single synchronous RAM. A stop byte inside a frame
// closes it; if the frame has at least three bytes and its first stored byte is
// the start byte, the type byte and the payload bytes come out as message beats
// (tuser = 0), tlast on the final one, with the payload length in tdata. A
// misplaced start or stop byte gives one framing-error beat, a full store one
// oversize-error beat; every master beat carries the three 16-bit wrapping error
// counters as they stand after that beat's update. A byte that does not close
// a frame is handled in the idle state. The closing byte of a delivered frame
// moves the block to a check state, which reads back the first stored byte, and
// then to a read state, which hands out the delivered bytes in turn through the
// RAM's single read port. A closed frame whose first stored byte is not the
// start byte is dropped in the check state, and a frame shorter than three
// bytes is dropped with its closing byte. The block takes a byte only in the
// idle state and when its output register is empty or being emptied in that
// cycle. No clearing pass follows reset: the store is only read at entries
// written in the current frame.
// Registers (write-only): index 0 start byte, 1 stop byte, 2 escape byte.
module byte_stuffing_deframer #(
  parameter int unsigned FRAME_DEPTH = bsd_pkg::FrameDepthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration write port.
  input  wire logic                        cfg_we_i,
  input  wire logic [bsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [bsd_pkg::ByteW-1:0]   cfg_wdata_i,
  // Line bytes in.
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] line_byte
  // Results out.
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [7:0] data_byte, [13:8] payload_len, [29:14] stuff_error_count,
  // [45:30] framing_error_count, [61:46] oversize_error_count, [63:62] zero
  output      logic [63:0]                 m_axis_tdata,
  output      logic                        m_axis_tlast,
  output      logic [1:0]                  m_axis_tuser    // [1:0] kind
);
  import bsd_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_DEPTH);

  cfg_t             cfg_q;
  res_t             res;
  res_t             out_q;
  logic             res_valid;
  logic             out_valid_q;
  logic             out_free;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ByteW-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [ByteW-1:0] mem_rdata;

  // Configuration registers; writes past the last index are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= StartByteRst;
      cfg_q.stop_byte   <= StopByteRst;
      cfg_q.escape_byte <= EscapeByteRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START:  cfg_q.start_byte  <= cfg_wdata_i;
        CFG_STOP:   cfg_q.stop_byte   <= cfg_wdata_i;
        CFG_ESCAPE: cfg_q.escape_byte <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  bsd_ctrl #(
    .Depth(FRAME_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .byte_valid_i(s_axis_tvalid),
    .byte_i      (s_axis_tdata),
    .byte_ready_o(s_axis_tready),
    .res_valid_o (res_valid),
    .res_ready_i (out_free),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bsd_ram #(
    .Width(ByteW),
    .Depth(FRAME_DEPTH)
  ) u_frame_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output register: a new beat may load when it is empty or being taken.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.is_last;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {2'b00, out_q.oversize_cnt, out_q.framing_cnt, out_q.stuff_cnt,
                          out_q.payload_len, out_q.data_byte};

endmodule

`default_nettype wire

FILE: verif/byte_stuffing_deframer_tb.sv
`default_nettype none

// Self-checking bench for the byte-stuffing deframer. Line bytes are pushed
// through the slave stream one beat at a time. Every beat that the block takes
// is also fed to a software copy of the deframer in the class below. That copy
// queues the result beats the byte should cause. Each master beat is then
// compared, field by field, against the oldest queued beat.
//
// The stimulus runs in this order:
//   - A short directed burst under the reset delimiters. It covers the minimum
//     frame, a stop outside a frame, a start inside a frame, escaped
//     delimiters, a double escape, a bad escape, a short frame and a frame
//     whose first stored byte is not the start byte.
//   - Five random phases; the first and last use the reset delimiters. One
//     phase has start equal to stop, and the byte values 0x00 and 0xFF are
//     used as delimiters. Most traffic is well-formed frames with random
//     content; the rest is line noise and broken frames.
//   - Full-length frames and store overruns are placed at fixed points of
//     some phases.
//
// Both sides stall in random bursts, except in the last phase. Once, the
// receiver holds off for a long stretch so that the block backs up into its
// input.
module byte_stuffing_deframer_tb;

  import bsd_pkg::*;

  localparam int unsigned FrameDepth  = FrameDepthDef;
  localparam int unsigned LongHold    = 300;
  // A closing byte of a full frame keeps the block busy through its whole readout.
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseItems  = 90;

  // Software deframer. It keeps the delimiters, the escape and framing state,
  // the frame store, the error counters and the queue of result beats still
  // owed by the block.
  class deframer_tracker;
    logic [ByteW-1:0] start_b, stop_b, esc_b;
    bit               esc_pend, in_msg;
    logic [ByteW-1:0] store_mem [FrameDepth];
    int unsigned      fill;
    logic [CntW-1:0]  n_stuff, n_framing, n_oversize;
    res_t             beats_due [$];
    int unsigned      fails;

    function new();
      start_b    = StartByteRst;
      stop_b     = StopByteRst;
      esc_b      = EscapeByteRst;
      esc_pend   = 1'b0;
      in_msg     = 1'b0;
      fill       = 0;
      n_stuff    = '0;
      n_framing  = '0;
      n_oversize = '0;
      fails      = 0;
    endfunction

    function void set_delims(logic [ByteW-1:0] st, logic [ByteW-1:0] sp,
                             logic [ByteW-1:0] es);
      start_b = st;
      stop_b  = sp;
      esc_b   = es;
    endfunction

    function int unsigned pending();
      return beats_due.size();
    endfunction

    // Counters are captured as they stand when the beat is produced.
    function res_t mk_beat(kind_e k, logic [ByteW-1:0] d, logic [PlenW-1:0] plen);
      res_t r;
      r.kind         = k;
      r.data_byte    = d;
      r.is_last      = 1'b0;
      r.payload_len  = plen;
      r.stuff_cnt    = n_stuff;
      r.framing_cnt  = n_framing;
      r.oversize_cnt = n_oversize;
      return r;
    endfunction

    function void keep(logic [ByteW-1:0] b);
      if (fill < FrameDepth) begin
        store_mem[fill] = b;
      end
      fill++;
    endfunction

    // The final beat that one line byte causes carries tlast.
    function void commit(res_t step_q [$]);
      if (step_q.size() != 0) begin
        step_q[step_q.size()-1].is_last = 1'b1;
      end
      foreach (step_q[i]) begin
        beats_due.push_back(step_q[i]);
      end
    endfunction

    function void take_line_byte(logic [ByteW-1:0] b);
      res_t        step_q [$];
      int unsigned len;
      if (b == esc_b) begin
        // A second escape just keeps the escape armed.
        esc_pend = 1'b1;
        return;
      end
      if (esc_pend) begin
        esc_pend = 1'b0;
        if ((b & StuffMask) != '0) begin
          in_msg = 1'b0;
          fill   = 0;
          n_stuff++;
          step_q.push_back(mk_beat(KIND_STUFF, '0, '0));
          commit(step_q);
          return;
        end
        // An escaped byte is plain data, even if it matches a delimiter.
        keep(b ^ StuffMask);
      end else begin
        keep(b);
        if (b == stop_b) begin
          if (in_msg) begin
            len    = fill;
            in_msg = 1'b0;
            fill   = 0;
            if (len >= MinFrame && len <= FrameDepth && store_mem[0] == start_b) begin
              for (int i = 1; i + 1 < len; i++) begin
                step_q.push_back(mk_beat(KIND_MSG, store_mem[i], PlenW'(len - MinFrame)));
              end
            end
            commit(step_q);
            return;
          end
          fill = 0;
          n_framing++;
          step_q.push_back(mk_beat(KIND_FRAMING, '0, '0));
        end
        // This still applies after a stray stop when start equals stop.
        if (b == start_b) begin
          if (in_msg) begin
            in_msg = 1'b0;
            fill   = 0;
            n_framing++;
            step_q.push_back(mk_beat(KIND_FRAMING, '0, '0));
          end else begin
            in_msg = 1'b1;
          end
        end
      end
      if (fill >= FrameDepth) begin
        fill   = 0;
        in_msg = 1'b0;
        n_oversize++;
        step_q.push_back(mk_beat(KIND_OVERSIZE, '0, '0));
      end
      commit(step_q);
    endfunction

    function void diff(string name, logic [CntW-1:0] want, logic [CntW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_out_beat(res_t got);
      res_t want;
      if (beats_due.size() == 0) begin
        $error("result beat with nothing expected: kind %0d data %0h", got.kind,
               got.data_byte);
        fails++;
        return;
      end
      want = beats_due.pop_front();
      diff("kind", want.kind, got.kind);
      diff("data_byte", want.data_byte, got.data_byte);
      diff("is_last", want.is_last, got.is_last);
      diff("payload_len", want.payload_len, got.payload_len);
      diff("stuff_error_count", want.stuff_cnt, got.stuff_cnt);
      diff("framing_error_count", want.framing_cnt, got.framing_cnt);
      diff("oversize_error_count", want.oversize_cnt, got.oversize_cnt);
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [ByteW-1:0] cfg_wdata;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // [7:0] line_byte
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // [7:0] data_byte, [13:8] payload_len, [29:14] stuff_error_count,
  // [45:30] framing_error_count, [61:46] oversize_error_count, [63:62] zero
  logic [63:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic [1:0]       m_axis_tuser;   // [1:0] kind

  deframer_tracker  sb;
  logic [7:0]       tx_q [$];
  int unsigned      items_sent = 0;
  int unsigned      cycle_cnt  = 0;
  bit               quiet      = 1'b0;
  bit               long_hold_req = 1'b0;

  byte_stuffing_deframer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog. It is far above the slowest legal run, long hold-off included.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // All inputs change only just after a rising edge. At the falling edge the
  // handshake signals therefore already hold the values that the next rising
  // edge will see, so both streams are observed here without a race.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_out_beat('{kind:         kind_e'(m_axis_tuser),
                          data_byte:    m_axis_tdata[7:0],
                          is_last:      m_axis_tlast,
                          payload_len:  m_axis_tdata[13:8],
                          stuff_cnt:    m_axis_tdata[29:14],
                          framing_cnt:  m_axis_tdata[45:30],
                          oversize_cnt: m_axis_tdata[61:46]});
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.take_line_byte(s_axis_tdata);
    end
  end

  // Receiver. It stalls in random bursts, or once for a long hold-off on
  // request. It never stalls once the run has gone quiet.
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LongHold;
      end else if (stall == 0 && !quiet && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(1, 16);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Sends one line byte. It may first leave a gap, and it returns just after
  // the edge that takes the beat. tvalid stays high on return, so that
  // back-to-back bytes never lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_all();
    foreach (tx_q[i]) begin
      send_byte(tx_q[i]);
    end
    tx_q.delete();
  endtask

  // Waits until every owed beat has arrived. It then waits a while longer,
  // because a dropped frame may still be in flight.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_delims(input logic [ByteW-1:0] st, input logic [ByteW-1:0] sp,
                             input logic [ByteW-1:0] es);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_START;
    cfg_wdata <= st;
    @(posedge clk_i);
    cfg_idx   <= CFG_STOP;
    cfg_wdata <= sp;
    @(posedge clk_i);
    cfg_idx   <= CFG_ESCAPE;
    cfg_wdata <= es;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_delims(st, sp, es);
  endtask

  function automatic bit is_delim(logic [7:0] v);
    return v == sb.start_b || v == sb.stop_b || v == sb.esc_b;
  endfunction

  // Queues one content byte the way a transmitter would stuff it. A delimiter
  // is escaped, and a value that cannot be escaped is swapped for another
  // one. Ordinary bytes with bit 5 set are sometimes escaped as well, and an
  // escape is sometimes doubled.
  function automatic void add_data(logic [7:0] d);
    logic [7:0] v;
    v = d;
    while (is_delim(v) && (!v[StuffBitPos] || (v ^ StuffMask) == sb.esc_b)) begin
      v = 8'($urandom);
    end
    if (is_delim(v) || (v[StuffBitPos] && (v ^ StuffMask) != sb.esc_b &&
                        $urandom_range(0, 15) == 0)) begin
      tx_q.push_back(sb.esc_b);
      if ($urandom_range(0, 7) == 0) begin
        tx_q.push_back(sb.esc_b);
      end
      tx_q.push_back(v ^ StuffMask);
    end else begin
      tx_q.push_back(v);
    end
  endfunction

  // Gets the deframer back to an empty store outside a frame, so that the
  // next frame lines up. It is skipped now and then to let misaligned frames
  // through.
  function automatic void resync();
    logic [7:0] v;
    if ($urandom_range(0, 4) == 0) begin
      return;
    end
    if (sb.esc_pend) begin
      do v = 8'($urandom) & ~StuffMask; while (v == sb.esc_b);
      tx_q.push_back(v);
    end
    if (sb.esc_pend || sb.fill != 0 || sb.in_msg) begin
      tx_q.push_back(sb.stop_b);
    end
  endfunction

  function automatic void build_frame(int unsigned plen);
    resync();
    tx_q.push_back(sb.start_b);
    add_data(8'($urandom));
    repeat (plen) add_data(8'($urandom));
    tx_q.push_back(sb.stop_b);
  endfunction

  // Line noise and broken frames.
  function automatic void build_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 3))
      0: begin
        repeat (n) tx_q.push_back(8'($urandom));
      end
      1: begin
        // Bad escape in the middle of a frame.
        tx_q.push_back(sb.start_b);
        repeat (n) add_data(8'($urandom));
        tx_q.push_back(sb.esc_b);
        tx_q.push_back(8'($urandom) | StuffMask);
      end
      2: begin
        // Second start before the first frame is closed.
        tx_q.push_back(sb.start_b);
        repeat (n) add_data(8'($urandom));
        tx_q.push_back(sb.start_b);
        repeat (n) add_data(8'($urandom));
        tx_q.push_back(sb.stop_b);
      end
      default: begin
        // Minimum frame followed by a stray stop.
        tx_q.push_back(sb.start_b);
        add_data(8'($urandom));
        tx_q.push_back(sb.stop_b);
        tx_q.push_back(sb.stop_b);
      end
    endcase
  endfunction

  // One random phase. A full-length frame (64 stored bytes, 62 result beats)
  // and a store overrun can be forced at fixed frame positions.
  task automatic run_phase(input bit with_full, input bit with_overrun);
    int unsigned goal;
    int unsigned frame_no;
    goal     = items_sent + PhaseItems;
    frame_no = 0;
    while (items_sent < goal) begin
      if (with_full && frame_no == 2) begin
        build_frame(FrameDepth - MinFrame);
      end else if (with_overrun && frame_no == 4) begin
        build_frame($urandom_range(FrameDepth - MinFrame + 1, FrameDepth + 2));
      end else if ($urandom_range(0, 4) == 0) begin
        build_noise();
      end else if ($urandom_range(0, 9) == 0) begin
        build_frame($urandom_range(13, 40));
      end else begin
        build_frame($urandom_range(0, 12));
      end
      send_all();
      frame_no++;
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_START;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed burst under the reset delimiters, one group per line:
    //   minimum frame with a zero type byte,
    //   stop outside a frame,
    //   start inside a frame,
    //   escaped start, double escape, escaped stop, then 0xFF and a close,
    //   escape followed by a byte with bit 5 set,
    //   frame too short to deliver,
    //   frame whose first stored byte is a leftover 0xFF.
    tx_q = '{StartByteRst, 8'h00, StopByteRst,
             StopByteRst,
             StartByteRst, StartByteRst,
             StartByteRst, EscapeByteRst, StartByteRst ^ StuffMask,
             EscapeByteRst, EscapeByteRst, StopByteRst ^ StuffMask, 8'hFF, StopByteRst,
             StartByteRst, 8'h11, EscapeByteRst, StartByteRst,
             StartByteRst, StopByteRst,
             8'hFF, StartByteRst, 8'h05, 8'h06, StopByteRst};
    send_all();

    // The long receiver hold-off lands while the sender keeps offering bytes.
    long_hold_req = 1'b1;
    run_phase(1'b1, 1'b0);
    drain();

    // Delimiters at the ends of the byte range.
    load_delims(8'h00, 8'hFF, 8'h80);
    run_phase(1'b0, 1'b1);
    drain();

    load_delims(8'hFF, 8'h00, 8'hE0);
    run_phase(1'b1, 1'b0);
    drain();

    // When start equals stop, a stray stop opens a frame as well.
    load_delims(8'h55, 8'h55, 8'hAA);
    run_phase(1'b0, 1'b1);
    drain();

    // Last phase, back on the reset delimiters with no stalls on either side.
    load_delims(StartByteRst, StopByteRst, EscapeByteRst);
    quiet = 1'b1;
    run_phase(1'b1, 1'b1);
    drain();

    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
